// ----- hw/rtl/nrdma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrdma_pkg
// shared constants of the remote dma register file: buffer geometry,
// register offsets, command and status bits, stream field layout
// ----------------------------------------------------------------------------
package nrdma_pkg;

    localparam int BUF_BYTES = 16384;
    localparam int BUF_BASE  = 16384;
    localparam int BUF_AW    = $clog2(BUF_BYTES);

    localparam int MAC_W     = 48;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    // host bus offsets
    localparam logic [4:0] OFF_DATA  = 5'h10;
    localparam logic [4:0] OFF_RESET = 5'h1F;

    // register file offsets (low four bits)
    localparam logic [3:0] REG_CMD    = 4'd0;
    localparam logic [3:0] REG_PSTART = 4'd1;
    localparam logic [3:0] REG_PSTOP  = 4'd2;
    localparam logic [3:0] REG_BNRY   = 4'd3;
    localparam logic [3:0] REG_TPSR   = 4'd4;
    localparam logic [3:0] REG_TBCR0  = 4'd5;
    localparam logic [3:0] REG_TBCR1  = 4'd6;
    localparam logic [3:0] REG_ISR    = 4'd7;
    localparam logic [3:0] REG_CURR   = 4'd7;
    localparam logic [3:0] REG_RSAR0  = 4'd8;
    localparam logic [3:0] REG_RSAR1  = 4'd9;
    localparam logic [3:0] REG_RBCR0  = 4'd10;
    localparam logic [3:0] REG_RBCR1  = 4'd11;
    localparam logic [3:0] REG_RCR    = 4'd12;
    localparam logic [3:0] REG_TCR    = 4'd13;
    localparam logic [3:0] REG_DCR    = 4'd14;
    localparam logic [3:0] REG_IMR    = 4'd15;
    localparam logic [3:0] REG_PAR0   = 4'd1;
    localparam logic [3:0] REG_PAR5   = 4'd6;

    localparam logic [1:0] PAGE0 = 2'd0;
    localparam logic [1:0] PAGE1 = 2'd1;
    localparam logic [1:0] PAGE2 = 2'd2;

    localparam logic [7:0] CMD_RESET_VAL = 8'h21;
    localparam logic [7:0] ISR_RESET_VAL = 8'h80;
    localparam int         CMD_STOP_BIT  = 0;
    localparam logic [7:0] CMD_REMOTE_RW = 8'h18;
    localparam int         ISR_RST_BIT   = 7;
    localparam int         ISR_RDC_BIT   = 6;
    localparam logic [7:0] NO_RAM_DATA   = 8'hFF;

endpackage : nrdma_pkg
`default_nettype wire

// ----- hw/rtl/nic_remote_dma_register_file_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nic_remote_dma_register_file_core
// paged host register file and remote dma data port of a network controller
// ----------------------------------------------------------------------------
// usage
//   s channel: one host bus request each, tuser = read (0) or write (1),
//   tdata = register offset and write byte. m channel: one response per
//   request with the read byte (0 for writes) and the interrupt line as
//   seen after the request. cfg channel: station address, always ready.
// response path
//   register requests and data port writes answer from the output register;
//   data port reads go through the registered read port of the buffer ram,
//   then the output register.
// throughput
//   one request per cycle while the response is not stalled; no new request
//   is taken while a data port read is in flight in the ram.
// reset
//   command 0x21, status 0x80, all else zero but the response payload;
//   buffer ram contents are undefined until written. no clearing pass.
// stall
//   the response waits in the output register; a new request is taken in
//   the cycle the waiting response leaves.
// ----------------------------------------------------------------------------
module nic_remote_dma_register_file_core (
    input  logic                           clk,
    input  logic                           rst_n,
    // cfg
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nrdma_pkg::MAC_W-1:0]    cfg_data,
    // request
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nrdma_pkg::S_DATA_W-1:0] s_tdata,   // reg_offset[4:0], write_data[12:5]
    input  logic                           s_tuser,   // action
    // response
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nrdma_pkg::M_DATA_W-1:0] m_tdata    // read_data[7:0], interrupt_line[8]
);

    import nrdma_pkg::*;

    logic [MAC_W-1:0] station_reg;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  pstart_reg, pstart_next;
    logic [7:0]  pstop_reg, pstop_next;
    logic [7:0]  bnry_reg, bnry_next;
    logic [7:0]  curr_reg, curr_next;
    logic [7:0]  tpsr_reg, tpsr_next;
    logic [15:0] tbcr_reg, tbcr_next;
    logic [7:0]  isr_reg, isr_next;
    logic [6:0]  imr_reg, imr_next;
    logic [15:0] rsar_reg, rsar_next;
    logic [15:0] rbcr_reg, rbcr_next;
    logic [7:0]  rcr_reg, rcr_next;
    logic [7:0]  tcr_reg, tcr_next;
    logic [7:0]  dcr_reg, dcr_next;

    logic        pend_reg, pend_next;
    logic        pend_rng_reg, pend_rng_next;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_int_reg;

    logic        acc;
    logic        wr;
    logic [4:0]  off;
    logic [3:0]  roff;
    logic [7:0]  wbyte;
    logic [1:0]  page;
    logic [7:0]  rd_comb;
    logic        int_next;
    logic [2:0]  par_idx;

    logic [16:0] rel_addr;
    logic        in_rng;
    logic [15:0] addr_inc;
    logic [15:0] addr_wrap;
    logic        ram_en;
    logic        ram_we;
    logic [7:0]  ram_q;

    assign acc   = s_tvalid && s_tready;
    assign wr    = s_tuser;
    assign off   = s_tdata[4:0];
    assign roff  = off[3:0];
    assign wbyte = s_tdata[12:5];
    assign page  = cmd_reg[7:6];

    assign par_idx  = 3'(roff - REG_PAR0);
    assign rel_addr = {1'b0, rsar_reg} - 17'(BUF_BASE);
    assign in_rng   = ({1'b0, rsar_reg} >= 17'(BUF_BASE)) && (rel_addr < 17'(BUF_BYTES));
    assign addr_inc = rsar_reg + 16'd1;
    assign addr_wrap = (addr_inc == {pstop_reg, 8'h00}) ? {pstart_reg, 8'h00} : addr_inc;

    // register file read mux
    always_comb
    begin
        rd_comb = 8'h00;
        if (roff == REG_CMD)
        begin
            rd_comb = cmd_reg;
        end
        else
        begin
            case (page)
                PAGE0:
                begin
                    case (roff)
                        REG_BNRY:  rd_comb = bnry_reg;
                        REG_ISR:   rd_comb = isr_reg;
                        REG_RSAR0: rd_comb = rsar_reg[7:0];
                        REG_RSAR1: rd_comb = rsar_reg[15:8];
                        default:   rd_comb = 8'h00;
                    endcase
                end
                PAGE1:
                begin
                    if (roff >= REG_PAR0 && roff <= REG_PAR5)
                    begin
                        rd_comb = station_reg[{par_idx, 3'b000} +: 8];
                    end
                    else if (roff == REG_CURR)
                    begin
                        rd_comb = curr_reg;
                    end
                end
                PAGE2:
                begin
                    case (roff)
                        REG_PSTART: rd_comb = pstart_reg;
                        REG_PSTOP:  rd_comb = pstop_reg;
                        REG_TPSR:   rd_comb = tpsr_reg;
                        REG_RCR:    rd_comb = rcr_reg;
                        REG_TCR:    rd_comb = tcr_reg;
                        REG_DCR:    rd_comb = dcr_reg;
                        REG_IMR:    rd_comb = {1'b0, imr_reg};
                        default:    rd_comb = 8'h00;
                    endcase
                end
                default: rd_comb = 8'h00;
            endcase
        end
        if (off[4] || wr)
        begin
            rd_comb = 8'h00;
        end
    end

    // request decode and register update
    always_comb
    begin
        cmd_next      = cmd_reg;
        pstart_next   = pstart_reg;
        pstop_next    = pstop_reg;
        bnry_next     = bnry_reg;
        curr_next     = curr_reg;
        tpsr_next     = tpsr_reg;
        tbcr_next     = tbcr_reg;
        isr_next      = isr_reg;
        imr_next      = imr_reg;
        rsar_next     = rsar_reg;
        rbcr_next     = rbcr_reg;
        rcr_next      = rcr_reg;
        tcr_next      = tcr_reg;
        dcr_next      = dcr_reg;
        pend_next     = 1'b0;
        pend_rng_next = in_rng;
        ram_en        = 1'b0;
        ram_we        = 1'b0;

        if (acc)
        begin
            if (!off[4])
            begin
                if (wr && roff == REG_CMD)
                begin
                    cmd_next = wbyte;
                    if (wbyte[CMD_STOP_BIT])
                    begin
                        isr_next[ISR_RST_BIT] = 1'b1;
                    end
                    else
                    begin
                        isr_next[ISR_RST_BIT] = 1'b0;
                        if (((wbyte & CMD_REMOTE_RW) != 8'h00) && rbcr_reg == 16'd0)
                        begin
                            isr_next[ISR_RDC_BIT] = 1'b1;
                        end
                    end
                end
                else if (wr && page == PAGE1)
                begin
                    if (roff == REG_CURR)
                    begin
                        curr_next = wbyte;
                    end
                end
                else if (wr && page == PAGE0)
                begin
                    unique case (roff)
                        REG_PSTART: pstart_next = wbyte;
                        REG_PSTOP:  pstop_next = wbyte;
                        REG_BNRY:   bnry_next = wbyte;
                        REG_TPSR:   tpsr_next = wbyte;
                        REG_TBCR0:  tbcr_next[7:0] = wbyte;
                        REG_TBCR1:  tbcr_next[15:8] = wbyte;
                        REG_ISR:    isr_next[6:0] = isr_reg[6:0] & ~wbyte[6:0];
                        REG_RSAR0:  rsar_next[7:0] = wbyte;
                        REG_RSAR1:  rsar_next[15:8] = wbyte;
                        REG_RBCR0:  rbcr_next[7:0] = wbyte;
                        REG_RBCR1:  rbcr_next[15:8] = wbyte;
                        REG_RCR:    rcr_next = wbyte;
                        REG_TCR:    tcr_next = wbyte;
                        REG_DCR:    dcr_next = wbyte;
                        REG_IMR:    imr_next = wbyte[6:0];
                        default:    ;
                    endcase
                end
            end
            else if (off == OFF_DATA)
            begin
                ram_en    = in_rng;
                ram_we    = wr;
                pend_next = !wr;
                rsar_next = addr_wrap;
                if (rbcr_reg <= 16'd1)
                begin
                    rbcr_next = 16'd0;
                    isr_next[ISR_RDC_BIT] = 1'b1;
                end
                else
                begin
                    rbcr_next = rbcr_reg - 16'd1;
                end
            end
            else if (off == OFF_RESET && !wr)
            begin
                cmd_next = CMD_RESET_VAL;
                isr_next[ISR_RST_BIT] = 1'b1;
            end
        end
    end

    assign int_next = |(isr_next[6:0] & imr_next);

    nrdma_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_buf_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (rel_addr[BUF_AW-1:0]),
        .wdata (wbyte),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg   <= '0;
            cmd_reg       <= CMD_RESET_VAL;
            pstart_reg    <= '0;
            pstop_reg     <= '0;
            bnry_reg      <= '0;
            curr_reg      <= '0;
            tpsr_reg      <= '0;
            tbcr_reg      <= '0;
            isr_reg       <= ISR_RESET_VAL;
            imr_reg       <= '0;
            rsar_reg      <= '0;
            rbcr_reg      <= '0;
            rcr_reg       <= '0;
            tcr_reg       <= '0;
            dcr_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_rng_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                station_reg <= cfg_data;
            end
            cmd_reg      <= cmd_next;
            pstart_reg   <= pstart_next;
            pstop_reg    <= pstop_next;
            bnry_reg     <= bnry_next;
            curr_reg     <= curr_next;
            tpsr_reg     <= tpsr_next;
            tbcr_reg     <= tbcr_next;
            isr_reg      <= isr_next;
            imr_reg      <= imr_next;
            rsar_reg     <= rsar_next;
            rbcr_reg     <= rbcr_next;
            rcr_reg      <= rcr_next;
            tcr_reg      <= tcr_next;
            dcr_reg      <= dcr_next;
            pend_reg     <= pend_next;
            pend_rng_reg <= pend_rng_next;
            if (pend_reg || (acc && !pend_next))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            out_data_reg <= pend_rng_reg ? ram_q : NO_RAM_DATA;
        end
        else if (acc)
        begin
            out_data_reg <= rd_comb;
        end
        if (acc)
        begin
            out_int_reg <= int_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = !pend_reg && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'b0, out_int_reg, out_data_reg};

endmodule : nic_remote_dma_register_file_core
`default_nettype wire

// ----- hw/rtl/nrdma_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrdma_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module nrdma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule : nrdma_ram
`default_nettype wire

// ----- hw/rtl/nrdma_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrdma_checker
// port-level checks of the remote dma register file, bound to the top level
// ----------------------------------------------------------------------------
module nrdma_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [nrdma_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [nrdma_pkg::M_DATA_W-1:0] m_tdata
);

    import nrdma_pkg::*;

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled response changed");

    // no new request while a response is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken over a stalled response");

    // write requests answer next cycle with a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tuser |=> m_tvalid && m_tdata[7:0] == 8'h00)
        else $error("write response missing or non-zero");

    // register reads answer next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !s_tuser && s_tdata[4:0] != OFF_DATA |=> m_tvalid)
        else $error("register read response late");

    // station address port never pushes back
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config request stalled");

endmodule : nrdma_checker

bind nic_remote_dma_register_file_core nrdma_checker u_nrdma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
`default_nettype wire
